@@ rtl/bbc_pkg.sv @@
// ============================================================================
// bbc_pkg
// Shared sizes, codes and control bundles of the LRU block buffer cache.
// ============================================================================
package bbc_pkg;

   // Table geometry
   localparam int ENTRIES = 32;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Field widths
   localparam int MODE_W   = 3;
   localparam int DEV_W    = 8;
   localparam int BLK_W    = 32;
   localparam int EIDX_W   = 5;
   localparam int DREQ_W   = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_FIELDS_W = EIDX_W + 1 + DREQ_W + BLK_W + STATUS_W;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELDS_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PIN     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_UNPIN   = 3'd4;

   // Disk request codes
   localparam logic [DREQ_W-1:0] DREQ_NONE  = 2'd0;
   localparam logic [DREQ_W-1:0] DREQ_FETCH = 2'd1;
   localparam logic [DREQ_W-1:0] DREQ_WRITE = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_COUNT   = 2'd2;

   // Tag memory write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [DEV_W-1:0] dev;
      logic [BLK_W-1:0] blk;
   } tag_wr_type;

   // Recency list update: move the entry at rank pos to the most recent place
   typedef struct packed {
      logic             move;
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] entry;
   } rec_ctl_type;

endpackage

@@ rtl/block_buffer_cache_lru.sv @@
// ============================================================================
// block_buffer_cache_lru
// LRU block buffer cache with reference counts, scanned by a sequencer.
// ============================================================================
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  req_    | in  | mode, device_id, block_number, entry_index
//  rsp_    | out | result_entry, tag_hit, disk_request, disk_block, status
//
//  A read scans the recency list from the most recent entry down, taking
//  S_HIT_ADDR and S_HIT_CMP for each entry; a miss, having compared every
//  entry, then scans from the least recent entry up for an unreferenced
//  victim in S_VICTIM. A release that frees an entry walks S_POS to its rank.
//  The tag scan is set by the one registered read port of the tag memory.
//  Reset is synchronous and restores counts, valid bits and the rank order.
//  The finished beat waits in the output register while the next is taken.
//
module block_buffer_cache_lru (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // mode[2:0], device_id[10:3], block_number[42:11], entry_index[47:43]
   input  logic [bbc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result_entry[4:0], tag_hit[5], disk_request[7:6], disk_block[39:8],
   // status[41:40], zero[47:42]
   output logic [bbc_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_HIT_ADDR, S_HIT_CMP, S_VICTIM, S_WB_DATA, S_POS, S_OUT
   } state_type;

   localparam logic [bbc_pkg::IDX_W-1:0] RANK_TOP = bbc_pkg::IDX_W'(bbc_pkg::ENTRIES - 1);

   state_type                       state_ff, state_in;
   logic [bbc_pkg::IDX_W-1:0]       rank_ff, rank_in;
   logic [bbc_pkg::IDX_W-1:0]       ent_ff, ent_in;
   logic [bbc_pkg::MODE_W-1:0]      mode_ff;
   logic [bbc_pkg::DEV_W-1:0]       dev_ff;
   logic [bbc_pkg::BLK_W-1:0]       blk_ff;
   logic [bbc_pkg::EIDX_W-1:0]      idx_ff;
   logic [bbc_pkg::EIDX_W-1:0]      res_entry_ff, res_entry_in;
   logic                            res_hit_ff, res_hit_in;
   logic [bbc_pkg::DREQ_W-1:0]      res_dreq_ff, res_dreq_in;
   logic [bbc_pkg::BLK_W-1:0]       res_dblk_ff, res_dblk_in;
   logic [bbc_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bbc_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [bbc_pkg::COUNT_W-1:0]     count_ff [bbc_pkg::ENTRIES];
   logic [bbc_pkg::ENTRIES-1:0]     valid_ff;

   logic [bbc_pkg::IDX_W-1:0]       sel_entry;
   logic [bbc_pkg::IDX_W-1:0]       idx_entry;
   logic                            idx_ok;
   logic [bbc_pkg::COUNT_W-1:0]     cnt_rd;
   logic                            vld_rd;
   logic                            cnt_we;
   logic [bbc_pkg::COUNT_W-1:0]     cnt_wdata;
   logic                            vld_set;
   logic                            tag_eq;
   logic [bbc_pkg::IDX_W-1:0]       rank_entry;
   logic [bbc_pkg::DEV_W-1:0]       tag_rd_dev;
   logic [bbc_pkg::BLK_W-1:0]       tag_rd_blk;
   bbc_pkg::tag_wr_type             tag_wr;
   bbc_pkg::rec_ctl_type            rec_ctl;
   logic                            out_free;

   assign idx_entry = bbc_pkg::IDX_W'(idx_ff);
   assign idx_ok    = int'(idx_ff) < bbc_pkg::ENTRIES;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Pick the one entry that the current step reads
   always_comb begin
      case (state_ff)
         S_HIT_ADDR, S_VICTIM: sel_entry = rank_entry;
         S_HIT_CMP:            sel_entry = ent_ff;
         default:              sel_entry = idx_entry;
      endcase
   end

   assign cnt_rd = count_ff[sel_entry];
   assign vld_rd = valid_ff[sel_entry];

   // Tag compare: an entry never fetched compares as holding all-zero tags
   assign tag_eq = vld_rd ? (tag_rd_dev == dev_ff && tag_rd_blk == blk_ff)
                          : (dev_ff == '0 && blk_ff == '0);

   bbc_tag_ram u_tag_ram (
      .clock   (clock),
      .wr      (tag_wr),
      .rd_addr (sel_entry),
      .rd_dev  (tag_rd_dev),
      .rd_blk  (tag_rd_blk)
   );

   bbc_recency u_recency (
      .clock       (clock),
      .reset       (reset),
      .ctl         (rec_ctl),
      .query_rank  (rank_ff),
      .query_entry (rank_entry)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      rank_in       = rank_ff;
      ent_in        = ent_ff;
      res_entry_in  = res_entry_ff;
      res_hit_in    = res_hit_ff;
      res_dreq_in   = res_dreq_ff;
      res_dblk_in   = res_dblk_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      cnt_we        = 1'b0;
      cnt_wdata     = cnt_rd;
      vld_set       = 1'b0;
      tag_wr        = '{en: 1'b0, addr: sel_entry, dev: dev_ff, blk: blk_ff};
      rec_ctl       = '{move: 1'b0, pos: rank_ff, entry: idx_entry};

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_entry_in  = idx_ff;
            res_hit_in    = 1'b0;
            res_dreq_in   = bbc_pkg::DREQ_NONE;
            res_dblk_in   = '0;
            res_status_in = bbc_pkg::ST_OK;
            state_in      = S_OUT;
            if (mode_ff == bbc_pkg::MODE_READ) begin
               rank_in  = RANK_TOP;
               state_in = S_HIT_ADDR;
            end else if (mode_ff > bbc_pkg::MODE_UNPIN) begin
               res_entry_in = '0;
            end else if (idx_ok) begin
               case (mode_ff)
                  bbc_pkg::MODE_WRITE: begin
                     state_in = S_WB_DATA;
                  end
                  bbc_pkg::MODE_PIN: begin
                     if (cnt_rd == bbc_pkg::COUNT_MAX) begin
                        res_status_in = bbc_pkg::ST_COUNT;
                     end else begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_rd + 1'b1;
                     end
                  end
                  default: begin
                     // release and unpin lower the count
                     if (cnt_rd == '0) begin
                        res_status_in = bbc_pkg::ST_COUNT;
                     end else begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_rd - 1'b1;
                        if (mode_ff == bbc_pkg::MODE_RELEASE &&
                            cnt_rd == bbc_pkg::COUNT_W'(1)) begin
                           rank_in  = '0;
                           state_in = S_POS;
                        end
                     end
                  end
               endcase
            end
         end

         S_HIT_ADDR: begin
            ent_in   = rank_entry;
            state_in = S_HIT_CMP;
         end

         S_HIT_CMP: begin
            if (tag_eq) begin
               res_entry_in  = bbc_pkg::EIDX_W'(ent_ff);
               res_hit_in    = 1'b1;
               res_dreq_in   = vld_rd ? bbc_pkg::DREQ_NONE : bbc_pkg::DREQ_FETCH;
               res_dblk_in   = vld_rd ? '0 : blk_ff;
               res_status_in = bbc_pkg::ST_OK;
               vld_set       = !vld_rd;
               // store the reset tags of an entry that becomes valid here
               tag_wr.en     = !vld_rd;
               if (cnt_rd == bbc_pkg::COUNT_MAX) begin
                  res_status_in = bbc_pkg::ST_COUNT;
               end else begin
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_rd + 1'b1;
               end
               state_in = S_OUT;
            end else if (rank_ff == '0) begin
               state_in = S_VICTIM;
            end else begin
               rank_in  = rank_ff - 1'b1;
               state_in = S_HIT_ADDR;
            end
         end

         S_VICTIM: begin
            if (cnt_rd == '0) begin
               tag_wr.en     = 1'b1;
               cnt_we        = 1'b1;
               cnt_wdata     = bbc_pkg::COUNT_W'(1);
               vld_set       = 1'b1;
               res_entry_in  = bbc_pkg::EIDX_W'(rank_entry);
               res_hit_in    = 1'b0;
               res_dreq_in   = bbc_pkg::DREQ_FETCH;
               res_dblk_in   = blk_ff;
               res_status_in = bbc_pkg::ST_OK;
               state_in      = S_OUT;
            end else if (rank_ff == RANK_TOP) begin
               res_entry_in  = '0;
               res_hit_in    = 1'b0;
               res_dreq_in   = bbc_pkg::DREQ_NONE;
               res_dblk_in   = '0;
               res_status_in = bbc_pkg::ST_NO_FREE;
               state_in      = S_OUT;
            end else begin
               rank_in = rank_ff + 1'b1;
            end
         end

         S_WB_DATA: begin
            res_dreq_in = bbc_pkg::DREQ_WRITE;
            res_dblk_in = vld_rd ? tag_rd_blk : '0;
            state_in    = S_OUT;
         end

         S_POS: begin
            if (rank_entry == idx_entry) begin
               rec_ctl.move = 1'b1;
               state_in     = S_OUT;
            end else begin
               rank_in = rank_ff + 1'b1;
            end
         end

         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {bbc_pkg::RSP_PAD_W'(0), res_status_ff, res_dblk_ff,
                               res_dreq_ff, res_hit_ff, res_entry_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, captured request and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (state_ff == S_IDLE && req_tvalid) begin
         mode_ff <= req_tdata[2:0];
         dev_ff  <= req_tdata[10:3];
         blk_ff  <= req_tdata[42:11];
         idx_ff  <= req_tdata[47:43];
      end
      rank_ff       <= rank_in;
      ent_ff        <= ent_in;
      res_entry_ff  <= res_entry_in;
      res_hit_ff    <= res_hit_in;
      res_dreq_ff   <= res_dreq_in;
      res_dblk_ff   <= res_dblk_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Reference counts and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bbc_pkg::ENTRIES; i++) begin
            count_ff[i] <= '0;
         end
         valid_ff <= '0;
      end else begin
         if (cnt_we) begin
            count_ff[sel_entry] <= cnt_wdata;
         end
         if (vld_set) begin
            valid_ff[sel_entry] <= 1'b1;
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/bbc_tag_ram.sv @@
// ============================================================================
// bbc_tag_ram
// Device and block tag memory, one write and one registered read per cycle.
// ============================================================================
module bbc_tag_ram (
   input  logic                           clock,
   input  bbc_pkg::tag_wr_type            wr,
   input  logic [bbc_pkg::IDX_W-1:0]      rd_addr,
   output logic [bbc_pkg::DEV_W-1:0]      rd_dev,
   output logic [bbc_pkg::BLK_W-1:0]      rd_blk
);

   logic [bbc_pkg::DEV_W-1:0] dev_mem_ff [bbc_pkg::ENTRIES];
   logic [bbc_pkg::BLK_W-1:0] blk_mem_ff [bbc_pkg::ENTRIES];
   logic [bbc_pkg::DEV_W-1:0] rd_dev_ff;
   logic [bbc_pkg::BLK_W-1:0] rd_blk_ff;

   // Write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr.en) begin
         dev_mem_ff[wr.addr] <= wr.dev;
         blk_mem_ff[wr.addr] <= wr.blk;
      end
      rd_dev_ff <= dev_mem_ff[rd_addr];
      rd_blk_ff <= blk_mem_ff[rd_addr];
   end

   assign rd_dev = rd_dev_ff;
   assign rd_blk = rd_blk_ff;

endmodule

@@ rtl/bbc_recency.sv @@
// ============================================================================
// bbc_recency
// Recency list: entry numbers ordered by rank, lowest rank least recent.
// ============================================================================
module bbc_recency (
   input  logic                           clock,
   input  logic                           reset,
   input  bbc_pkg::rec_ctl_type           ctl,
   input  logic [bbc_pkg::IDX_W-1:0]      query_rank,
   output logic [bbc_pkg::IDX_W-1:0]      query_entry
);

   logic [bbc_pkg::IDX_W-1:0] order_ff [bbc_pkg::ENTRIES];
   logic [bbc_pkg::IDX_W-1:0] order_in [bbc_pkg::ENTRIES];

   // Look up the entry holding a rank
   assign query_entry = order_ff[query_rank];

   // Close the gap above pos and append the entry at the top
   always_comb begin
      for (int i = 0; i < bbc_pkg::ENTRIES; i++) begin
         order_in[i] = order_ff[i];
      end
      if (ctl.move) begin
         for (int i = 0; i < bbc_pkg::ENTRIES - 1; i++) begin
            if (bbc_pkg::IDX_W'(i) >= ctl.pos) begin
               order_in[i] = order_ff[i+1];
            end
         end
         order_in[bbc_pkg::ENTRIES-1] = ctl.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bbc_pkg::ENTRIES; i++) begin
            order_ff[i] <= bbc_pkg::IDX_W'(i);
         end
      end else begin
         for (int i = 0; i < bbc_pkg::ENTRIES; i++) begin
            order_ff[i] <= order_in[i];
         end
      end
   end

endmodule

@@ rtl/bbc_checker.sv @@
// ============================================================================
// bbc_checker
// Port-level checks of the buffer cache, bound to the top level.
// ============================================================================
module bbc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [bbc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bbc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Take one request at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is at work");

   // Drop the disk block when no disk request goes out
   a_no_disk_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7:6] == bbc_pkg::DREQ_NONE |-> rsp_tdata[39:8] == '0)
      else $error("disk block set without a disk request");

   // A full table reports nothing else
   a_no_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[41:40] == bbc_pkg::ST_NO_FREE
      |-> rsp_tdata[4:0] == '0 && !rsp_tdata[5] && rsp_tdata[7:6] == bbc_pkg::DREQ_NONE)
      else $error("no-free status with a granted entry");

   // A hit never writes back
   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5] |-> rsp_tdata[7:6] != bbc_pkg::DREQ_WRITE)
      else $error("hit with a write back request");

endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (.*);

@@ tb/block_buffer_cache_lru_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// block_buffer_cache_lru_tb
// Self-checking bench for the LRU buffer cache. A short table of directed
// beats runs first, then random read, release, pin, unpin and write-back
// traffic with fill, saturate and drain sequences. Every response beat is
// compared field by field with its fixed row or a behavioral tag table model.
// ============================================================================
module block_buffer_cache_lru_tb;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TARGET_BEATS = 1700;
   localparam int POOL_SIZE    = 48;
   localparam int TAIL_CYCLES  = 4 * bbc_pkg::ENTRIES + 40;
   localparam int MAX_REPORTS  = 40;
   localparam int RX_HOLD_A    = 3000;
   localparam int RX_HOLD_B    = 60000;
   localparam int RX_HOLD_LEN  = 600;

   // Reserved mode codes, ignored by the block
   localparam logic [bbc_pkg::MODE_W-1:0] MODE_RSVD_FIRST = 3'd5;
   localparam logic [bbc_pkg::MODE_W-1:0] MODE_RSVD_MID   = 3'd6;
   localparam logic [bbc_pkg::MODE_W-1:0] MODE_RSVD_LAST  = 3'd7;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SLOW} rx_style_type;

   typedef struct {
      logic [bbc_pkg::MODE_W-1:0] mode;
      logic [bbc_pkg::DEV_W-1:0]  dev;
      logic [bbc_pkg::BLK_W-1:0]  blk;
      logic [bbc_pkg::EIDX_W-1:0] idx;
   } req_beat_type;

   typedef struct {
      logic [bbc_pkg::EIDX_W-1:0]   entry;
      logic                         hit;
      logic [bbc_pkg::DREQ_W-1:0]   dreq;
      logic [bbc_pkg::BLK_W-1:0]    dblk;
      logic [bbc_pkg::STATUS_W-1:0] status;
   } rsp_beat_type;

   typedef struct {
      req_beat_type req;
      bit           fixed;
      rsp_beat_type want;
   } dir_row_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [bbc_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [bbc_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // Model copy of the tag table
   logic [bbc_pkg::DEV_W-1:0] cache_dev   [bbc_pkg::ENTRIES];
   logic [bbc_pkg::BLK_W-1:0] cache_blk   [bbc_pkg::ENTRIES];
   bit                        cache_valid [bbc_pkg::ENTRIES];
   int                        cache_refs  [bbc_pkg::ENTRIES];
   int                        cache_rank  [bbc_pkg::ENTRIES];

   rsp_beat_type              expected_rsp [$];
   dir_row_type               dir_table [$];
   rsp_beat_type              last_grant;
   rsp_beat_type              blank_rsp;
   logic [bbc_pkg::DEV_W-1:0] pool_dev [POOL_SIZE];
   logic [bbc_pkg::BLK_W-1:0] pool_blk [POOL_SIZE];

   int           mismatches  = 0;
   int           sent_beats  = 0;
   int           burst_left  = 0;
   int           cycle_count = 0;
   int           rx_cycle    = 0;
   rx_style_type rx_style    = RX_OPEN;

   block_buffer_cache_lru u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Put the table into its reset state: empty tags, rank equal to index
   function automatic void cache_clear();
      int i;
      for (i = 0; i < bbc_pkg::ENTRIES; i++) begin
         cache_dev[i]   = '0;
         cache_blk[i]   = '0;
         cache_valid[i] = 1'b0;
         cache_refs[i]  = 0;
         cache_rank[i]  = i;
      end
   endfunction

   // Apply one request to the table and return the response it produces
   function automatic rsp_beat_type cache_step(input req_beat_type rq);
      rsp_beat_type rs;
      int           found;
      int           best;
      int           i;
      int           old_rank;
      rs.entry  = '0;
      rs.hit    = 1'b0;
      rs.dreq   = bbc_pkg::DREQ_NONE;
      rs.dblk   = '0;
      rs.status = bbc_pkg::ST_OK;
      if (rq.mode == bbc_pkg::MODE_READ) begin
         // hit: most recent matching entry wins
         found = -1;
         best  = -1;
         for (i = 0; i < bbc_pkg::ENTRIES; i++) begin
            if (cache_dev[i] == rq.dev && cache_blk[i] == rq.blk &&
                cache_rank[i] > best) begin
               found = i;
               best  = cache_rank[i];
            end
         end
         if (found >= 0) begin
            rs.entry = bbc_pkg::EIDX_W'(found);
            rs.hit   = 1'b1;
            if (cache_refs[found] == bbc_pkg::COUNT_MAX) begin
               rs.status = bbc_pkg::ST_COUNT;
            end else begin
               cache_refs[found]++;
            end
            // a tag left over from reset still needs its data fetched
            if (!cache_valid[found]) begin
               rs.dreq            = bbc_pkg::DREQ_FETCH;
               rs.dblk            = rq.blk;
               cache_valid[found] = 1'b1;
            end
         end else begin
            // miss: least recent unreferenced entry becomes the victim
            best = bbc_pkg::ENTRIES;
            for (i = 0; i < bbc_pkg::ENTRIES; i++) begin
               if (cache_refs[i] == 0 && cache_rank[i] < best) begin
                  found = i;
                  best  = cache_rank[i];
               end
            end
            if (found >= 0) begin
               cache_dev[found]   = rq.dev;
               cache_blk[found]   = rq.blk;
               cache_refs[found]  = 1;
               cache_valid[found] = 1'b1;
               rs.entry           = bbc_pkg::EIDX_W'(found);
               rs.dreq            = bbc_pkg::DREQ_FETCH;
               rs.dblk            = rq.blk;
            end else begin
               rs.status = bbc_pkg::ST_NO_FREE;
            end
         end
      end else if (rq.mode > bbc_pkg::MODE_UNPIN) begin
         rs.entry = '0;
      end else if (int'(rq.idx) >= bbc_pkg::ENTRIES) begin
         rs.entry = rq.idx;
      end else begin
         i        = int'(rq.idx);
         rs.entry = rq.idx;
         case (rq.mode)
            bbc_pkg::MODE_WRITE: begin
               rs.dreq = bbc_pkg::DREQ_WRITE;
               rs.dblk = cache_blk[i];
            end
            bbc_pkg::MODE_PIN: begin
               if (cache_refs[i] == bbc_pkg::COUNT_MAX) begin
                  rs.status = bbc_pkg::ST_COUNT;
               end else begin
                  cache_refs[i]++;
               end
            end
            default: begin
               if (cache_refs[i] == 0) begin
                  rs.status = bbc_pkg::ST_COUNT;
               end else begin
                  cache_refs[i]--;
                  // a release that frees the entry moves it to most recent
                  if (rq.mode == bbc_pkg::MODE_RELEASE && cache_refs[i] == 0) begin
                     old_rank = cache_rank[i];
                     for (best = 0; best < bbc_pkg::ENTRIES; best++) begin
                        if (cache_rank[best] > old_rank) begin
                           cache_rank[best]--;
                        end
                     end
                     cache_rank[i] = bbc_pkg::ENTRIES - 1;
                  end
               end
            end
         endcase
      end
      return rs;
   endfunction

   function automatic void add_row(input logic [bbc_pkg::MODE_W-1:0] mode,
                                   input logic [bbc_pkg::DEV_W-1:0] dev,
                                   input logic [bbc_pkg::BLK_W-1:0] blk,
                                   input logic [bbc_pkg::EIDX_W-1:0] idx,
                                   input bit fixed,
                                   input logic [bbc_pkg::EIDX_W-1:0] entry,
                                   input logic hit,
                                   input logic [bbc_pkg::DREQ_W-1:0] dreq,
                                   input logic [bbc_pkg::BLK_W-1:0] dblk,
                                   input logic [bbc_pkg::STATUS_W-1:0] status);
      dir_row_type row;
      row.req.mode     = mode;
      row.req.dev      = dev;
      row.req.blk      = blk;
      row.req.idx      = idx;
      row.fixed        = fixed;
      row.want.entry   = entry;
      row.want.hit     = hit;
      row.want.dreq    = dreq;
      row.want.dblk    = dblk;
      row.want.status  = status;
      dir_table.push_back(row);
   endfunction

   function automatic req_beat_type entry_beat(input logic [bbc_pkg::MODE_W-1:0] mode,
                                               input int e);
      req_beat_type rq;
      rq.mode = mode;
      rq.dev  = bbc_pkg::DEV_W'($urandom);
      rq.blk  = $urandom;
      rq.idx  = bbc_pkg::EIDX_W'(e);
      return rq;
   endfunction

   function automatic req_beat_type read_beat(input logic [bbc_pkg::DEV_W-1:0] dev,
                                              input logic [bbc_pkg::BLK_W-1:0] blk);
      req_beat_type rq;
      rq.mode = bbc_pkg::MODE_READ;
      rq.dev  = dev;
      rq.blk  = blk;
      rq.idx  = bbc_pkg::EIDX_W'($urandom);
      return rq;
   endfunction

   task automatic report_mismatch(input string what, input logic [bbc_pkg::BLK_W-1:0] want,
                                  input logic [bbc_pkg::BLK_W-1:0] got);
      if (mismatches < MAX_REPORTS) begin
         $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
      end
      mismatches++;
   endtask

   // Offer one beat in bursts with random gaps; predict it once accepted
   task automatic send_beat(input req_beat_type rq, input bit fixed, input rsp_beat_type want);
      rsp_beat_type predicted;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
                                                   : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rq.idx, rq.blk, rq.dev, rq.mode};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = cache_step(rq);
      expected_rsp.push_back(fixed ? want : predicted);
      last_grant = predicted;
      burst_left--;
      sent_beats++;
   endtask

   task automatic offer(input req_beat_type rq);
      send_beat(rq, 1'b0, blank_rsp);
   endtask

   // Mixed traffic; count changes aim mostly at entries that are held
   task automatic mixed_run(input int n);
      req_beat_type rq;
      int           pick;
      int           k;
      int           held [$];
      repeat (n) begin
         held.delete();
         for (k = 0; k < bbc_pkg::ENTRIES; k++) begin
            if (cache_refs[k] != 0) held.push_back(k);
         end
         rq   = entry_beat(bbc_pkg::MODE_READ, $urandom_range(0, bbc_pkg::ENTRIES - 1));
         pick = $urandom_range(0, 99);
         if (pick < 38) begin
            if ($urandom_range(0, 4) < 3) begin
               k      = $urandom_range(0, POOL_SIZE - 1);
               rq.dev = pool_dev[k];
               rq.blk = pool_blk[k];
            end
         end else if (pick < 46) begin
            rq.mode = bbc_pkg::MODE_WRITE;
         end else if (pick < 76) begin
            rq.mode = bbc_pkg::MODE_RELEASE;
         end else if (pick < 84) begin
            rq.mode = bbc_pkg::MODE_PIN;
         end else if (pick < 96) begin
            rq.mode = bbc_pkg::MODE_UNPIN;
         end else begin
            rq.mode = bbc_pkg::MODE_W'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
         end
         if ((rq.mode == bbc_pkg::MODE_RELEASE || rq.mode == bbc_pkg::MODE_UNPIN ||
              rq.mode == bbc_pkg::MODE_PIN)
             && held.size() > 0 && $urandom_range(0, 99) < 85) begin
            rq.idx = bbc_pkg::EIDX_W'(held[$urandom_range(0, held.size() - 1)]);
         end
         offer(rq);
      end
   endtask

   // Drop every held entry back to zero, ending each with a release
   task automatic drain_all();
      int start;
      int k;
      int e;
      start = $urandom_range(0, bbc_pkg::ENTRIES - 1);
      for (k = 0; k < bbc_pkg::ENTRIES; k++) begin
         e = (start + k) % bbc_pkg::ENTRIES;
         while (cache_refs[e] > 1) offer(entry_beat(bbc_pkg::MODE_UNPIN, e));
         if (cache_refs[e] == 1) offer(entry_beat(bbc_pkg::MODE_RELEASE, e));
      end
   endtask

   // Fresh tags until no entry is free, then release everything
   task automatic fill_and_drain();
      repeat (bbc_pkg::ENTRIES + 4) offer(read_beat(bbc_pkg::DEV_W'($urandom), $urandom));
      drain_all();
   endtask

   // Walk one entry's count up past its ceiling and back down past zero
   task automatic saturate_run();
      int e;
      drain_all();
      offer(read_beat(bbc_pkg::DEV_W'($urandom), $urandom));
      e = int'(last_grant.entry);
      while (cache_refs[e] < bbc_pkg::COUNT_MAX) offer(entry_beat(bbc_pkg::MODE_PIN, e));
      repeat (3) offer(entry_beat(bbc_pkg::MODE_PIN, e));
      repeat (2) offer(read_beat(cache_dev[e], cache_blk[e]));
      while (cache_refs[e] > 0) offer(entry_beat(bbc_pkg::MODE_UNPIN, e));
      offer(entry_beat(bbc_pkg::MODE_UNPIN, e));
      offer(entry_beat(bbc_pkg::MODE_RELEASE, e));
   endtask

   // Response check against the oldest expectation
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response beat", '0,
                            rsp_tdata[bbc_pkg::BLK_W-1:0]);
         end else begin
            want = expected_rsp.pop_front();
            // result_entry[4:0], tag_hit[5], disk_request[7:6], disk_block[39:8],
            // status[41:40]
            if (rsp_tdata[4:0] !== want.entry)
               report_mismatch("result_entry", bbc_pkg::BLK_W'(want.entry),
                               bbc_pkg::BLK_W'(rsp_tdata[4:0]));
            if (rsp_tdata[5] !== want.hit)
               report_mismatch("tag_hit", bbc_pkg::BLK_W'(want.hit),
                               bbc_pkg::BLK_W'(rsp_tdata[5]));
            if (rsp_tdata[7:6] !== want.dreq)
               report_mismatch("disk_request", bbc_pkg::BLK_W'(want.dreq),
                               bbc_pkg::BLK_W'(rsp_tdata[7:6]));
            if (rsp_tdata[39:8] !== want.dblk)
               report_mismatch("disk_block", want.dblk, rsp_tdata[39:8]);
            if (rsp_tdata[41:40] !== want.status)
               report_mismatch("status", bbc_pkg::BLK_W'(want.status),
                               bbc_pkg::BLK_W'(rsp_tdata[41:40]));
         end
      end
   end

   // Receiver: change stall style now and then, hold off for two long windows
   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 700 == 0) rx_style = rx_style_type'($urandom_range(0, 3));
      if ((rx_cycle >= RX_HOLD_A && rx_cycle < RX_HOLD_A + RX_HOLD_LEN) ||
          (rx_cycle >= RX_HOLD_B && rx_cycle < RX_HOLD_B + RX_HOLD_LEN)) begin
         rsp_tready <= 1'b0;
      end else begin
         case (rx_style)
            RX_OPEN:     rsp_tready <= 1'b1;
            RX_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_tready <= ((rx_cycle % 5) != 0);
            default:     rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int k;
      blank_rsp = '{entry: '0, hit: 1'b0, dreq: bbc_pkg::DREQ_NONE, dblk: '0,
                    status: bbc_pkg::ST_OK};
      cache_clear();
      for (k = 0; k < POOL_SIZE; k++) begin
         pool_dev[k] = bbc_pkg::DEV_W'($urandom);
         pool_blk[k] = $urandom;
      end

      // underflow, write-back and hit on the reset tag, then fetch and reuse
      add_row(bbc_pkg::MODE_UNPIN, 8'h00, 32'h0, 5'd0, 1'b1, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_COUNT);
      add_row(bbc_pkg::MODE_RELEASE, 8'h00, 32'h0, 5'd31, 1'b1, 5'd31, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_COUNT);
      add_row(bbc_pkg::MODE_WRITE, 8'h00, 32'h0, 5'd5, 1'b1, 5'd5, 1'b0,
              bbc_pkg::DREQ_WRITE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_READ, 8'h00, 32'h0, 5'd31, 1'b1, 5'd31, 1'b1,
              bbc_pkg::DREQ_FETCH, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_READ, 8'hFF, 32'hFFFFFFFF, 5'd0, 1'b1, 5'd0, 1'b0,
              bbc_pkg::DREQ_FETCH, 32'hFFFFFFFF, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_READ, 8'hFF, 32'hFFFFFFFF, 5'd0, 1'b1, 5'd0, 1'b1,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_WRITE, 8'h00, 32'h0, 5'd0, 1'b1, 5'd0, 1'b0,
              bbc_pkg::DREQ_WRITE, 32'hFFFFFFFF, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_PIN, 8'h12, 32'h0, 5'd0, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_UNPIN, 8'h00, 32'h0, 5'd0, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_RELEASE, 8'h00, 32'h0, 5'd0, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_RELEASE, 8'h00, 32'h0, 5'd0, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_READ, 8'hAA, 32'h55555555, 5'd10, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_READ, 8'h55, 32'hAAAAAAAA, 5'd21, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      // reserved modes answer all zeros
      add_row(MODE_RSVD_FIRST, 8'hFF, 32'hFFFFFFFF, 5'd31, 1'b1, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(MODE_RSVD_MID, 8'h5A, 32'h12345678, 5'd9, 1'b1, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(MODE_RSVD_LAST, 8'h00, 32'h0, 5'd0, 1'b1, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_WRITE, 8'h00, 32'h0, 5'd31, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_PIN, 8'h00, 32'h0, 5'd31, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_READ, 8'h00, 32'h0, 5'd3, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_READ, 8'h01, 32'h0, 5'd3, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_READ, 8'h00, 32'h1, 5'd3, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_UNPIN, 8'h00, 32'h0, 5'd31, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_RELEASE, 8'h00, 32'h0, 5'd31, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);
      add_row(bbc_pkg::MODE_RELEASE, 8'h00, 32'h0, 5'd31, 1'b0, 5'd0, 1'b0,
              bbc_pkg::DREQ_NONE, 32'h0, bbc_pkg::ST_OK);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[r]) send_beat(dir_table[r].req, dir_table[r].fixed,
                                       dir_table[r].want);

      mixed_run(200);
      fill_and_drain();
      mixed_run(250);
      saturate_run();
      mixed_run(200);
      fill_and_drain();
      while (sent_beats < TARGET_BEATS) mixed_run(50);
      req_tvalid <= 1'b0;

      // wait out the outstanding responses, then look for strays
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
